// ----- rtl/indexed_min_heap_unit_macros.svh -----
// Assertion macros for the indexed min-heap unit
`ifndef INDEXED_MIN_HEAP_UNIT_MACROS_SVH
`define INDEXED_MIN_HEAP_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define IMH_ASSERT_IMPLY(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("imh assertion failed");
`define IMH_ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("imh assertion failed");
`else
`define IMH_ASSERT_IMPLY(label, clk, rst_n, a, c)
`define IMH_ASSERT_NEXT(label, clk, rst_n, a, c)
`endif
`endif

// ----- rtl/imh_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package imh_pkg;
    localparam int CMD_W   = 2;
    localparam int NODE_W  = 12;
    localparam int KEYIO_W = 32;
    localparam int STAT_W  = 2;
    localparam int FILL_W  = 11;

    localparam logic [CMD_W-1:0] CMD_INSERT   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_EXTRACT  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DECREASE = 2'd2;
    localparam logic [CMD_W-1:0] CMD_NONE     = 2'd3;

    localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL   = 2'd2;
    localparam logic [STAT_W-1:0] ST_ABSENT = 2'd3;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_PRD,
        S_LRD,
        S_UCHK,
        S_URD,
        S_XRD,
        S_DCHK,
        S_DRD,
        S_RESP
    } t_state;
endpackage
`default_nettype wire

// ----- rtl/imh_cmd_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
interface imh_cmd_if;
    logic                        valid;
    logic                        ready;
    logic [imh_pkg::CMD_W-1:0]   command;
    logic [imh_pkg::NODE_W-1:0]  node_index;
    logic [imh_pkg::KEYIO_W-1:0] new_key;
    modport source (output valid, command, node_index, new_key, input ready);
    modport sink (input valid, command, node_index, new_key, output ready);
endinterface
`default_nettype wire

// ----- rtl/imh_res_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
interface imh_res_if;
    logic                        valid;
    logic                        ready;
    logic [imh_pkg::NODE_W-1:0]  out_index;
    logic [imh_pkg::KEYIO_W-1:0] out_key;
    logic [imh_pkg::STAT_W-1:0]  status;
    logic [imh_pkg::FILL_W-1:0]  fill_count;
    modport source (output valid, out_index, out_key, status, fill_count, input ready);
    modport sink (input valid, out_index, out_key, status, fill_count, output ready);
endinterface
`default_nettype wire

// ----- rtl/indexed_min_heap_unit.sv -----
// Indexed binary min-heap of (key, node) pairs with a node-to-slot map. One
// command is taken at a time: insert, extract-min or decrease-key, each
// answered by exactly one result transaction. Heap slots and the position
// map live in RAMs with registered read data; sift-up and sift-down handle
// each heap level by presenting the address, then taking the read data and
// comparing/writing back. After reset a clearing pass writes every entry of
// the position map to mark every node absent; no command is taken until it
// ends. A finished result sits in an output register, so the next command
// can start while it waits to be taken.
`timescale 1ns / 1ps
`default_nettype none
`include "indexed_min_heap_unit_macros.svh"
module indexed_min_heap_unit #(
    parameter int CAPACITY = 1024,
    parameter int NODES    = 4096,
    parameter int KEY_BITS = 32
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    imh_cmd_if.sink    i_cmd,
    imh_res_if.source  o_res
);
    localparam int KW = (KEY_BITS < imh_pkg::KEYIO_W) ? KEY_BITS : imh_pkg::KEYIO_W;
    localparam int AW = $clog2(CAPACITY);
    localparam int PW = $clog2(CAPACITY + 1);
    localparam int NW = $clog2(NODES);
    localparam int NODE_W = imh_pkg::NODE_W;

    imh_pkg::t_state r_state, n_state;
    logic [imh_pkg::CMD_W-1:0]  r_cmd;
    logic [NODE_W-1:0]          r_node, r_lnode, r_rnode;
    logic [KW-1:0]              r_key, r_lkey, r_rkey;
    logic [imh_pkg::STAT_W-1:0] r_rstat, n_rstat;
    logic [PW-1:0]              r_count, n_count, r_pos, n_pos;
    logic [NW-1:0]              r_clr;
    logic                       r_ov;
    logic [NODE_W-1:0]          r_o_index;
    logic [imh_pkg::KEYIO_W-1:0] r_o_key;
    logic [imh_pkg::STAT_W-1:0] r_o_stat;
    logic [imh_pkg::FILL_W-1:0] r_o_fill;

    logic [AW-1:0]     s_ra, s_rb, s_wa;
    logic              s_we;
    logic [KW-1:0]     s_wkey, ka, kb;
    logic [NODE_W-1:0] s_wnode, na, nb;
    logic [NW-1:0]     p_ra, p_wa;
    logic              p_we;
    logic [PW-1:0]     p_wd, p_rd;

    logic              accept, out_free, node_bad, pick_b, sink_ok;
    logic [PW:0]       child, cidx;
    logic [KW-1:0]     ckey;
    logic [NODE_W-1:0] cnode;
    logic [PW-1:0]     parent;

    imh_slot_ram #(.DEPTH(CAPACITY), .KW(KW)) u_slot (
        .i_clk(i_clk), .i_ra_addr(s_ra), .i_rb_addr(s_rb),
        .o_ra_key(ka), .o_ra_node(na), .o_rb_key(kb), .o_rb_node(nb),
        .i_we(s_we), .i_waddr(s_wa), .i_wkey(s_wkey), .i_wnode(s_wnode)
    );

    imh_pos_ram #(.DEPTH(NODES), .DW(PW)) u_pos (
        .i_clk(i_clk), .i_raddr(p_ra), .o_rdata(p_rd),
        .i_we(p_we), .i_waddr(p_wa), .i_wdata(p_wd)
    );

    assign i_cmd.ready      = (r_state == imh_pkg::S_IDLE);
    assign accept           = i_cmd.valid && i_cmd.ready;
    assign out_free         = !r_ov || o_res.ready;
    assign o_res.valid      = r_ov;
    assign o_res.out_index  = r_o_index;
    assign o_res.out_key    = r_o_key;
    assign o_res.status     = r_o_stat;
    assign o_res.fill_count = r_o_fill;

    assign node_bad = ({{(32-NODE_W){1'b0}}, i_cmd.node_index} >= 32'(NODES));
    assign child    = {r_pos, 1'b0};
    assign parent   = r_pos >> 1;
    assign pick_b   = (child < {1'b0, r_count}) && (ka > kb);
    assign cidx     = pick_b ? child + 1'b1 : child;
    assign ckey     = pick_b ? kb : ka;
    assign cnode    = pick_b ? nb : na;
    assign sink_ok  = (r_lkey <= ckey);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            imh_pkg::S_CLEAR: begin
                if (r_clr == NW'(NODES - 1)) n_state = imh_pkg::S_IDLE;
            end
            imh_pkg::S_IDLE: begin
                if (accept) begin
                    if (i_cmd.command == imh_pkg::CMD_EXTRACT) begin
                        n_state = (r_count == '0) ? imh_pkg::S_RESP : imh_pkg::S_XRD;
                    end else if (i_cmd.command == imh_pkg::CMD_INSERT ||
                                 i_cmd.command == imh_pkg::CMD_DECREASE) begin
                        n_state = node_bad ? imh_pkg::S_RESP : imh_pkg::S_PRD;
                    end else begin
                        n_state = imh_pkg::S_RESP;
                    end
                end
            end
            imh_pkg::S_PRD: begin
                if (p_rd != '0) n_state = imh_pkg::S_LRD;
                else if (r_cmd == imh_pkg::CMD_DECREASE) n_state = imh_pkg::S_RESP;
                else if (r_count >= PW'(CAPACITY)) n_state = imh_pkg::S_RESP;
                else n_state = imh_pkg::S_UCHK;
            end
            imh_pkg::S_LRD:  n_state = (r_key < ka) ? imh_pkg::S_UCHK : imh_pkg::S_RESP;
            imh_pkg::S_UCHK: n_state = (r_pos == PW'(1)) ? imh_pkg::S_RESP : imh_pkg::S_URD;
            imh_pkg::S_URD:  n_state = (r_key > ka) ? imh_pkg::S_RESP : imh_pkg::S_UCHK;
            imh_pkg::S_XRD:  n_state = (r_count == PW'(1)) ? imh_pkg::S_RESP : imh_pkg::S_DCHK;
            imh_pkg::S_DCHK: begin
                n_state = (child > {1'b0, r_count}) ? imh_pkg::S_RESP : imh_pkg::S_DRD;
            end
            imh_pkg::S_DRD:  n_state = sink_ok ? imh_pkg::S_RESP : imh_pkg::S_DCHK;
            imh_pkg::S_RESP: if (out_free) n_state = imh_pkg::S_IDLE;
            default:         n_state = imh_pkg::S_IDLE;
        endcase
    end

    // memory control and datapath
    always_comb begin
        s_ra    = '0;
        s_rb    = '0;
        s_we    = 1'b0;
        s_wa    = AW'(r_pos - 1'b1);
        s_wkey  = r_key;
        s_wnode = r_node;
        p_ra    = NW'(i_cmd.node_index);
        p_we    = 1'b0;
        p_wa    = NW'(r_node);
        p_wd    = r_pos;
        n_count = r_count;
        n_pos   = r_pos;
        n_rstat = r_rstat;
        case (r_state)
            imh_pkg::S_CLEAR: begin
                p_we = 1'b1;
                p_wa = r_clr;
                p_wd = '0;
            end
            imh_pkg::S_IDLE: begin
                s_ra = '0;
                s_rb = AW'(r_count - 1'b1);
                if (accept) begin
                    if (i_cmd.command == imh_pkg::CMD_EXTRACT) begin
                        n_rstat = (r_count == '0) ? imh_pkg::ST_EMPTY : imh_pkg::ST_OK;
                    end else if ((i_cmd.command == imh_pkg::CMD_INSERT ||
                                  i_cmd.command == imh_pkg::CMD_DECREASE) && node_bad) begin
                        n_rstat = imh_pkg::ST_ABSENT;
                    end else begin
                        n_rstat = imh_pkg::ST_OK;
                    end
                end
            end
            imh_pkg::S_PRD: begin
                s_ra  = AW'(p_rd - 1'b1);
                n_pos = p_rd;
                if (p_rd == '0) begin
                    if (r_cmd == imh_pkg::CMD_DECREASE) begin
                        n_rstat = imh_pkg::ST_ABSENT;
                    end else if (r_count >= PW'(CAPACITY)) begin
                        n_rstat = imh_pkg::ST_FULL;
                    end else begin
                        n_count = r_count + 1'b1;
                        n_pos   = r_count + 1'b1;
                    end
                end
            end
            imh_pkg::S_UCHK: begin
                s_ra = AW'(parent - 1'b1);
                if (r_pos == PW'(1)) begin
                    s_we = 1'b1;
                    p_we = 1'b1;
                end
            end
            imh_pkg::S_URD: begin
                s_we = 1'b1;
                p_we = 1'b1;
                if (!(r_key > ka)) begin
                    s_wkey  = ka;
                    s_wnode = na;
                    p_wa    = NW'(na);
                    n_pos   = parent;
                end
            end
            imh_pkg::S_XRD: begin
                p_we    = 1'b1;
                p_wa    = NW'(na);
                p_wd    = '0;
                n_count = r_count - 1'b1;
                n_pos   = PW'(1);
            end
            imh_pkg::S_DCHK: begin
                s_ra = AW'(child - 1'b1);
                s_rb = AW'(child);
                if (child > {1'b0, r_count}) begin
                    s_we    = 1'b1;
                    s_wkey  = r_lkey;
                    s_wnode = r_lnode;
                    p_we    = 1'b1;
                    p_wa    = NW'(r_lnode);
                end
            end
            imh_pkg::S_DRD: begin
                s_we = 1'b1;
                p_we = 1'b1;
                if (sink_ok) begin
                    s_wkey  = r_lkey;
                    s_wnode = r_lnode;
                    p_wa    = NW'(r_lnode);
                end else begin
                    s_wkey  = ckey;
                    s_wnode = cnode;
                    p_wa    = NW'(cnode);
                    n_pos   = PW'(cidx);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= imh_pkg::S_CLEAR;
            r_clr   <= '0;
            r_count <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (r_state == imh_pkg::S_CLEAR) r_clr <= r_clr + 1'b1;
            if (r_state == imh_pkg::S_RESP && out_free) begin
                r_ov <= 1'b1;
            end else if (o_res.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos   <= n_pos;
        r_rstat <= n_rstat;
        if (accept) begin
            r_cmd   <= i_cmd.command;
            r_node  <= i_cmd.node_index;
            r_key   <= KW'(i_cmd.new_key);
            r_rnode <= i_cmd.node_index;
            r_rkey  <= '0;
        end
        if (r_state == imh_pkg::S_XRD) begin
            r_rnode <= na;
            r_rkey  <= ka;
            r_lkey  <= kb;
            r_lnode <= nb;
        end
        if (r_state == imh_pkg::S_RESP && out_free) begin
            r_o_index <= r_rnode;
            r_o_key   <= imh_pkg::KEYIO_W'(r_rkey);
            r_o_stat  <= r_rstat;
            r_o_fill  <= imh_pkg::FILL_W'(r_count);
        end
    end

    `IMH_ASSERT_IMPLY(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= PW'(CAPACITY))
    `IMH_ASSERT_NEXT(a_resp_loads, i_clk, i_rst_n, r_state == imh_pkg::S_RESP && out_free, r_ov)
    `IMH_ASSERT_NEXT(a_extract_dec, i_clk, i_rst_n, r_state == imh_pkg::S_XRD, r_count == $past(r_count) - 1'b1)
endmodule
`default_nettype wire

// ----- rtl/imh_slot_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
module imh_slot_ram #(
    parameter int DEPTH = 1024,
    parameter int KW    = 32
) (
    input  wire logic                       i_clk,
    input  wire logic [$clog2(DEPTH)-1:0]   i_ra_addr,
    input  wire logic [$clog2(DEPTH)-1:0]   i_rb_addr,
    output logic      [KW-1:0]              o_ra_key,
    output logic      [imh_pkg::NODE_W-1:0] o_ra_node,
    output logic      [KW-1:0]              o_rb_key,
    output logic      [imh_pkg::NODE_W-1:0] o_rb_node,
    input  wire logic                       i_we,
    input  wire logic [$clog2(DEPTH)-1:0]   i_waddr,
    input  wire logic [KW-1:0]              i_wkey,
    input  wire logic [imh_pkg::NODE_W-1:0] i_wnode
);
    logic [KW+imh_pkg::NODE_W-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= {i_wkey, i_wnode};
        end
        {o_ra_key, o_ra_node} <= mem[i_ra_addr];
        {o_rb_key, o_rb_node} <= mem[i_rb_addr];
    end
endmodule
`default_nettype wire

// ----- rtl/imh_pos_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
module imh_pos_ram #(
    parameter int DEPTH = 4096,
    parameter int DW    = 11
) (
    input  wire logic                     i_clk,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [DW-1:0]            o_rdata,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [DW-1:0]            i_wdata
);
    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end
endmodule
`default_nettype wire

// ----- tb/indexed_min_heap_unit_tb.sv -----
`timescale 1ns / 1ps
module indexed_min_heap_unit_tb;

    localparam int CAP = 1024;
    localparam int NUM_NODES = 4096;
    localparam int IDLE_LIMIT = 20000;

    typedef struct packed {
        logic [imh_pkg::NODE_W-1:0]  node;
        logic [imh_pkg::KEYIO_W-1:0] key;
        logic [imh_pkg::STAT_W-1:0]  status;
        logic [imh_pkg::FILL_W-1:0]  fill;
    } t_heap_reply;

    logic i_clk;
    logic i_rst_n;

    imh_cmd_if cmd_ch();
    imh_res_if res_ch();

    indexed_min_heap_unit i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_ch.sink),
        .o_res   (res_ch.source)
    );

    // shadow heap, slots 1..count
    logic [imh_pkg::KEYIO_W-1:0] hp_key [1:CAP];
    logic [imh_pkg::NODE_W-1:0]  hp_node [1:CAP];
    int                          node_slot [NUM_NODES];
    int                          hp_count;

    t_heap_reply                 pending_replies[$];
    int                          error_count = 0;
    int                          idle_cycles;
    int                          send_idle_pct;
    int                          recv_idle_pct;
    logic [imh_pkg::NODE_W-1:0]  live_nodes[$];

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    function automatic void place(int pos, logic [imh_pkg::KEYIO_W-1:0] k,
                                  logic [imh_pkg::NODE_W-1:0] n);
        hp_key[pos] = k;
        hp_node[pos] = n;
        node_slot[n] = pos;
    endfunction

    function automatic void sift_up(int pos, logic [imh_pkg::KEYIO_W-1:0] k,
                                    logic [imh_pkg::NODE_W-1:0] n);
        while (pos > 1) begin
            if (k > hp_key[pos >> 1])
                break;
            place(pos, hp_key[pos >> 1], hp_node[pos >> 1]);
            pos = pos >> 1;
        end
        place(pos, k, n);
    endfunction

    function automatic t_heap_reply predict_heap(logic [imh_pkg::CMD_W-1:0] cmd,
                                                 logic [imh_pkg::NODE_W-1:0] n,
                                                 logic [imh_pkg::KEYIO_W-1:0] k);
        t_heap_reply r;
        logic [imh_pkg::KEYIO_W-1:0] lk;
        logic [imh_pkg::NODE_W-1:0] ln;
        int pos;
        int c;
        r.node = n;
        r.key = '0;
        r.status = imh_pkg::ST_OK;
        if (cmd == imh_pkg::CMD_INSERT || cmd == imh_pkg::CMD_DECREASE) begin
            if (cmd == imh_pkg::CMD_DECREASE && node_slot[n] == 0) begin
                r.status = imh_pkg::ST_ABSENT;
            end else if (node_slot[n] != 0) begin
                if (k < hp_key[node_slot[n]])
                    sift_up(node_slot[n], k, n);
            end else if (hp_count >= CAP) begin
                r.status = imh_pkg::ST_FULL;
            end else begin
                hp_count++;
                sift_up(hp_count, k, n);
            end
        end else if (cmd == imh_pkg::CMD_EXTRACT) begin
            if (hp_count == 0) begin
                r.status = imh_pkg::ST_EMPTY;
            end else begin
                r.node = hp_node[1];
                r.key = hp_key[1];
                node_slot[hp_node[1]] = 0;
                lk = hp_key[hp_count];
                ln = hp_node[hp_count];
                hp_count--;
                if (hp_count > 0) begin
                    pos = 1;
                    for (c = 2; c <= hp_count; c = c << 1) begin
                        if (c < hp_count && hp_key[c] > hp_key[c + 1])
                            c++;
                        if (lk <= hp_key[c])
                            break;
                        place(pos, hp_key[c], hp_node[c]);
                        pos = c;
                    end
                    place(pos, lk, ln);
                end
            end
        end
        r.fill = imh_pkg::FILL_W'(hp_count);
        return r;
    endfunction

    task automatic send_command(input logic [imh_pkg::CMD_W-1:0] cmd,
                                input logic [imh_pkg::NODE_W-1:0] n,
                                input logic [imh_pkg::KEYIO_W-1:0] k);
        while ($urandom_range(99) < send_idle_pct) begin
            cmd_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        cmd_ch.valid <= 1'b1;
        cmd_ch.command <= cmd;
        cmd_ch.node_index <= n;
        cmd_ch.new_key <= k;
        do @(posedge i_clk); while (!cmd_ch.ready);
        pending_replies.push_back(predict_heap(cmd, n, k));
        if (cmd == imh_pkg::CMD_INSERT && pending_replies[$].status == imh_pkg::ST_OK)
            live_nodes.push_back(n);
    endtask

    always @(posedge i_clk) begin
        t_heap_reply want;
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                if (pending_replies.size() == 0) begin
                    report_mismatch("unexpected transaction", res_ch.out_index, 0);
                end else begin
                    want = pending_replies.pop_front();
                    if (res_ch.out_index !== want.node)
                        report_mismatch("out_index", res_ch.out_index, want.node);
                    if (res_ch.out_key !== want.key)
                        report_mismatch("out_key", res_ch.out_key, want.key);
                    if (res_ch.status !== want.status)
                        report_mismatch("status", res_ch.status, want.status);
                    if (res_ch.fill_count !== want.fill)
                        report_mismatch("fill_count", res_ch.fill_count, want.fill);
                end
            end
            res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic logic [imh_pkg::NODE_W-1:0] pick_node();
        if (live_nodes.size() > 0 && $urandom_range(1))
            return live_nodes[$urandom_range(live_nodes.size() - 1)];
        return imh_pkg::NODE_W'($urandom_range(NUM_NODES - 1));
    endfunction

    function automatic logic [imh_pkg::KEYIO_W-1:0] pick_key();
        case ($urandom_range(3))
            0: return imh_pkg::KEYIO_W'($urandom_range(15));
            1: return 32'hFFFF_FFF0 | imh_pkg::KEYIO_W'($urandom_range(15));
            default: return $urandom;
        endcase
    endfunction

    task automatic drain();
        cmd_ch.valid <= 1'b0;
        while (pending_replies.size() > 0)
            @(posedge i_clk);
    endtask

    task automatic test_directed();
        send_command(imh_pkg::CMD_EXTRACT, 12'hABC, 32'h1234);
        send_command(imh_pkg::CMD_DECREASE, 12'h005, 32'h0);
        send_command(imh_pkg::CMD_INSERT, 12'hFFF, 32'hFFFF_FFFF);
        send_command(imh_pkg::CMD_INSERT, 12'h000, 32'h0000_0000);
        send_command(imh_pkg::CMD_INSERT, 12'h555, 32'h0000_0000);
        send_command(imh_pkg::CMD_INSERT, 12'hAAA, 32'h5555_5555);
        send_command(imh_pkg::CMD_INSERT, 12'h123, 32'hAAAA_AAAA);
        send_command(imh_pkg::CMD_INSERT, 12'hFFF, 32'h1000_0000);
        send_command(imh_pkg::CMD_DECREASE, 12'h123, 32'hFFFF_FFFF);
        send_command(imh_pkg::CMD_DECREASE, 12'h123, 32'h0000_0001);
        send_command(imh_pkg::CMD_DECREASE, 12'h124, 32'h0000_0001);
        send_command(imh_pkg::CMD_NONE, 12'h777, 32'hDEAD_BEEF);
        repeat (7)
            send_command(imh_pkg::CMD_EXTRACT, 12'h3C3, 32'h0);
        live_nodes.delete();
    endtask

    task automatic test_full_heap();
        int i;
        while (hp_count > 0)
            send_command(imh_pkg::CMD_EXTRACT, pick_node(), 32'h0);
        live_nodes.delete();
        for (i = 0; i < CAP; i++)
            send_command(imh_pkg::CMD_INSERT, imh_pkg::NODE_W'(i), $urandom);
        send_command(imh_pkg::CMD_INSERT, 12'hF00, 32'h1);
        send_command(imh_pkg::CMD_INSERT, 12'h010, 32'h0);
        for (i = 0; i < 40; i++)
            send_command(imh_pkg::CMD_EXTRACT, pick_node(), pick_key());
        send_command(imh_pkg::CMD_INSERT, 12'hF01, 32'h2);
    endtask

    task automatic test_random(input int n_items);
        int i;
        int r;
        logic [imh_pkg::CMD_W-1:0] cmd;
        for (i = 0; i < n_items; i++) begin
            r = $urandom_range(99);
            if (r < 45) cmd = imh_pkg::CMD_INSERT;
            else if (r < 75) cmd = imh_pkg::CMD_EXTRACT;
            else if (r < 97) cmd = imh_pkg::CMD_DECREASE;
            else cmd = imh_pkg::CMD_NONE;
            send_command(cmd, pick_node(), pick_key());
            if (live_nodes.size() > 200)
                void'(live_nodes.pop_front());
        end
    endtask

    initial begin
        hp_count = 0;
        foreach (node_slot[i]) node_slot[i] = 0;
        send_idle_pct = 23;
        recv_idle_pct = 78;
        i_rst_n = 1'b0;
        cmd_ch.valid = 1'b0;
        cmd_ch.command = imh_pkg::CMD_INSERT;
        cmd_ch.node_index = '0;
        cmd_ch.new_key = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(50);
        send_idle_pct = 78;
        recv_idle_pct = 23;
        test_random(50);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_full_heap();
        test_random(40);
        drain();
        repeat (50) @(posedge i_clk);
        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
